// ----- src/sse_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// sse_pkg: shared constants of the serial shift engine
// widths, operation codes and configuration register indexes
// no dependencies
package sse_pkg;

    localparam int MAX_BITS = 64;
    localparam int IDX_W    = $clog2(MAX_BITS);
    localparam int CNT_W    = $clog2(MAX_BITS + 1);

    // fixed field widths of the stream items
    localparam int OP_W        = 2;
    localparam int WORD_W      = 64;
    localparam int BIT_COUNT_W = 7;
    localparam int IN_DATA_W   = 72;
    localparam int OUT_DATA_W  = 72;

    localparam int CFG_INDEX_W = 8;
    localparam int CFG_DATA_W  = 8;
    localparam int DELAY_W     = 8;

    localparam logic [OP_W-1:0] OP_TICK = 2'd0;
    localparam logic [OP_W-1:0] OP_OUT  = 2'd1;
    localparam logic [OP_W-1:0] OP_IN   = 2'd2;

    localparam logic [CFG_INDEX_W-1:0] CFG_LEAD_MSB    = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_HIGH_TICKS  = 8'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_LOW_TICKS   = 8'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_SAMPLE_PRE  = 8'd3;

endpackage
`default_nettype wire

// ----- src/serial_shift_engine.sv -----
`timescale 1ns / 1ps
`default_nettype none
// serial_shift_engine: serial clock/data master driven one tick per input item
// depends on sse_pkg
//
// usage:
//   s_axis carries one item per pin tick. tuser is the op: tick, start shift
//   out or start shift in. a start is itself the first tick of its transfer.
//   m_axis returns exactly one result per item: pin levels after the tick,
//   busy, a done pulse, the gathered read word and a refused-start flag.
//   the cfg channel writes the bit order, clock high/low extra ticks and the
//   sampling mode; it is always ready and is meant to be used while idle.
// throughput:
//   one item per cycle unless the output stalls. an item's result is in the
//   output register in the cycle after its transfer; pin state update and
//   result compute are one combinational pass from state to that register.
// reset:
//   synchronous, active low. all state, config and the output register clear,
//   pins low, read word zero.
// stall:
//   while a result waits with m_axis_tready low, s_axis_tready drops; the
//   output register takes the next result in the cycle the old one leaves.
module serial_shift_engine (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              s_axis_tvalid,
    output logic                                   s_axis_tready,
    // [63:0] shift_word, [70:64] bit_count, [71] data_in_level
    input  wire logic [sse_pkg::IN_DATA_W-1:0]     s_axis_tdata,
    // [1:0] op
    input  wire logic [sse_pkg::OP_W-1:0]          s_axis_tuser,
    output logic                                   m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    // [0] clock_level, [1] data_out_level, [2] busy_res, [3] done_res,
    // [67:4] read_word, [68] bad_request, [71:69] zero
    output logic [sse_pkg::OUT_DATA_W-1:0]         m_axis_tdata,
    input  wire logic                              i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  wire logic [sse_pkg::CFG_INDEX_W-1:0]   i_cfg_index,
    input  wire logic [sse_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_HIGH = 2'd1;
    localparam logic [1:0] PH_LOW  = 2'd2;

    // configuration
    logic                              r_lead_msb;
    logic [sse_pkg::DELAY_W-1:0]       r_high_ticks;
    logic [sse_pkg::DELAY_W-1:0]       r_low_ticks;
    logic                              r_sample_pre;

    // engine state
    logic [sse_pkg::MAX_BITS-1:0]      r_send_word,     n_send_word;
    logic [sse_pkg::MAX_BITS-1:0]      r_gathered_word, n_gathered_word;
    logic [sse_pkg::MAX_BITS-1:0]      r_bit_mask,      n_bit_mask;
    logic [sse_pkg::CNT_W-1:0]         r_bits_left,     n_bits_left;
    logic [1:0]                        r_phase,         n_phase;
    logic [sse_pkg::DELAY_W-1:0]       r_delay_count,   n_delay_count;
    logic                              r_reading,       n_reading;
    logic                              r_clock_reg,     n_clock_reg;
    logic                              r_data_reg,      n_data_reg;

    logic                              r_out_valid;
    logic [sse_pkg::OUT_DATA_W-1:0]    r_out_data;

    logic                              in_fire;
    logic [sse_pkg::OP_W-1:0]          in_op;
    logic [sse_pkg::WORD_W-1:0]        in_word;
    logic [sse_pkg::BIT_COUNT_W-1:0]   in_cnt;
    logic                              in_din;
    logic [sse_pkg::IDX_W-1:0]         cnt_m1;
    logic [sse_pkg::MAX_BITS-1:0]      first_mask;
    logic [sse_pkg::MAX_BITS-1:0]      next_mask;
    logic                              bad;
    logic                              done;
    logic [sse_pkg::WORD_W-1:0]        read_ext;
    logic [sse_pkg::OUT_DATA_W-1:0]    n_out_data;

    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign in_op         = s_axis_tuser;
    assign in_word       = s_axis_tdata[63:0];
    assign in_cnt        = s_axis_tdata[70:64];
    assign in_din        = s_axis_tdata[71];
    // wraps so that a full-width count points at the top bit
    assign cnt_m1        = in_cnt[sse_pkg::IDX_W-1:0] - sse_pkg::IDX_W'(1);

    assign o_cfg_ready   = 1'b1;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    always_comb begin
        first_mask = '0;
        if (r_lead_msb) begin
            first_mask[cnt_m1] = 1'b1;
        end else begin
            first_mask[0] = 1'b1;
        end
        next_mask = r_lead_msb ? (r_bit_mask >> 1) : (r_bit_mask << 1);
    end

    always_comb begin
        n_send_word     = r_send_word;
        n_gathered_word = r_gathered_word;
        n_bit_mask      = r_bit_mask;
        n_bits_left     = r_bits_left;
        n_phase         = r_phase;
        n_delay_count   = r_delay_count;
        n_reading       = r_reading;
        n_clock_reg     = r_clock_reg;
        n_data_reg      = r_data_reg;
        bad             = 1'b0;
        done            = 1'b0;
        if (in_fire) begin
            if (in_op == sse_pkg::OP_OUT || in_op == sse_pkg::OP_IN) begin
                if (r_phase != PH_IDLE || in_cnt == '0
                        || in_cnt > sse_pkg::BIT_COUNT_W'(sse_pkg::MAX_BITS)) begin
                    bad = 1'b1;
                end else begin
                    n_reading   = (in_op == sse_pkg::OP_IN);
                    n_bits_left = in_cnt[sse_pkg::CNT_W-1:0];
                    n_bit_mask  = first_mask;
                    if (n_reading) begin
                        n_gathered_word = (r_sample_pre && in_din) ? first_mask : '0;
                    end else begin
                        n_send_word = in_word[sse_pkg::MAX_BITS-1:0];
                        n_data_reg  = |(n_send_word & first_mask);
                    end
                    n_clock_reg   = 1'b1;
                    n_phase       = PH_HIGH;
                    n_delay_count = r_high_ticks;
                end
            end else begin
                unique case (r_phase)
                    PH_HIGH: begin
                        if (r_delay_count != '0) begin
                            n_delay_count = r_delay_count - 8'd1;
                        end else begin
                            n_clock_reg   = 1'b0;
                            n_phase       = PH_LOW;
                            n_delay_count = r_low_ticks;
                        end
                    end
                    PH_LOW: begin
                        if (r_delay_count != '0) begin
                            n_delay_count = r_delay_count - 8'd1;
                        end else begin
                            // post-pulse sample lands on the bit just clocked
                            if (r_reading && !r_sample_pre && in_din) begin
                                n_gathered_word = n_gathered_word | r_bit_mask;
                            end
                            if (r_bits_left > sse_pkg::CNT_W'(1)) begin
                                n_bits_left = r_bits_left - sse_pkg::CNT_W'(1);
                                n_bit_mask  = next_mask;
                                if (r_reading && r_sample_pre && in_din) begin
                                    n_gathered_word = n_gathered_word | next_mask;
                                end
                                if (!r_reading) begin
                                    n_data_reg = |(r_send_word & next_mask);
                                end
                                n_clock_reg   = 1'b1;
                                n_phase       = PH_HIGH;
                                n_delay_count = r_high_ticks;
                            end else begin
                                n_bits_left   = '0;
                                n_bit_mask    = '0;
                                n_reading     = 1'b0;
                                n_clock_reg   = 1'b0;
                                n_phase       = PH_IDLE;
                                n_delay_count = '0;
                                done          = 1'b1;
                            end
                        end
                    end
                    default: begin
                        n_phase = PH_IDLE;
                    end
                endcase
            end
        end
    end

    always_comb begin
        read_ext = '0;
        read_ext[sse_pkg::MAX_BITS-1:0] = n_gathered_word;
        n_out_data = {3'b000, bad, read_ext, done, (n_phase != PH_IDLE),
                      n_data_reg, n_clock_reg};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lead_msb   <= 1'b0;
            r_high_ticks <= '0;
            r_low_ticks  <= '0;
            r_sample_pre <= 1'b0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                sse_pkg::CFG_LEAD_MSB:   r_lead_msb   <= i_cfg_data[0];
                sse_pkg::CFG_HIGH_TICKS: r_high_ticks <= i_cfg_data;
                sse_pkg::CFG_LOW_TICKS:  r_low_ticks  <= i_cfg_data;
                sse_pkg::CFG_SAMPLE_PRE: r_sample_pre <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_send_word     <= '0;
            r_gathered_word <= '0;
            r_bit_mask      <= '0;
            r_bits_left     <= '0;
            r_phase         <= PH_IDLE;
            r_delay_count   <= '0;
            r_reading       <= 1'b0;
            r_clock_reg     <= 1'b0;
            r_data_reg      <= 1'b0;
            r_out_valid     <= 1'b0;
        end else begin
            r_send_word     <= n_send_word;
            r_gathered_word <= n_gathered_word;
            r_bit_mask      <= n_bit_mask;
            r_bits_left     <= n_bits_left;
            r_phase         <= n_phase;
            r_delay_count   <= n_delay_count;
            r_reading       <= n_reading;
            r_clock_reg     <= n_clock_reg;
            r_data_reg      <= n_data_reg;
            if (in_fire) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_data <= '0;
        end else if (in_fire) begin
            r_out_data <= n_out_data;
        end
    end

    // clock pin is high exactly in the high phase
    a_clock_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clock_reg == (r_phase == PH_HIGH))
        else $error("clock level out of step with phase");

    // idle engine holds no bits and no mask
    a_idle_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_IDLE) |-> (r_bits_left == '0 && r_bit_mask == '0))
        else $error("idle with bits pending");

    a_mask_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(r_bit_mask))
        else $error("bit mask has more than one bit set");

    // a valid start while idle always launches the first pulse
    a_start_launch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && (in_op == sse_pkg::OP_OUT || in_op == sse_pkg::OP_IN)
            && r_phase == PH_IDLE && in_cnt != '0
            && in_cnt <= sse_pkg::BIT_COUNT_W'(sse_pkg::MAX_BITS))
        |=> (r_phase == PH_HIGH && r_bits_left != '0))
        else $error("start did not launch a pulse");

endmodule
`default_nettype wire

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 1ps
// testbench: self-checking bench for serial_shift_engine, one stream item per pin tick
// a built-in pin-timing predictor checks every result; needs sse_pkg and the engine rtl
module testbench;
    import sse_pkg::*;

    localparam logic [OP_W-1:0] OP_SPARE = 2'd3;   // undefined op, behaves as a tick
    localparam int TOTAL_ITEMS  = 1750;
    localparam int N_PHASES     = 10;
    localparam int TAIL_CYCLES  = 20;
    localparam int unsigned CYCLE_LIMIT = 2000000;

    typedef enum logic [1:0] {ENG_IDLE, ENG_HIGH, ENG_LOW} t_eng_phase;
    typedef enum logic [1:0] {ROW_ITEM, ROW_TICKS, ROW_CFG} t_row_kind;

    typedef struct packed {
        logic        bad;
        logic [63:0] rd;
        logic        done;
        logic        busy;
        logic        dout;
        logic        clk;
    } t_pins;

    typedef struct {
        t_row_kind              kind;
        logic [OP_W-1:0]        op;
        logic [WORD_W-1:0]      word;
        logic [BIT_COUNT_W-1:0] cnt;
        logic                   din;
        logic                   typed;
        t_pins                  want;
        logic [CFG_INDEX_W-1:0] reg_idx;
        logic [CFG_DATA_W-1:0]  reg_val;
        int                     reps;    // ticks to send, 0 means until the transfer ends
    } t_plan_row;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_DATA_W-1:0]   s_axis_tdata = '0;
    logic [OP_W-1:0]        s_axis_tuser = OP_TICK;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0]  m_axis_tdata;
    logic                   i_cfg_valid = 1'b0;
    logic                   o_cfg_ready;
    logic [CFG_INDEX_W-1:0] i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]  i_cfg_data = '0;

    serial_shift_engine DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    // 12 ns period
    always #6 i_clk = ~i_clk;

    // predictor copy of the engine registers
    logic       cfg_lead_msb = 1'b0;
    logic [7:0] cfg_high = '0;
    logic [7:0] cfg_low = '0;
    logic       cfg_pre = 1'b0;

    logic [63:0] eng_send = '0;
    logic [63:0] eng_gather = '0;
    logic [63:0] eng_mask = '0;
    logic [6:0]  eng_left = '0;
    t_eng_phase  eng_phase = ENG_IDLE;
    logic [7:0]  eng_delay = '0;
    logic        eng_reading = 1'b0;
    logic        eng_clk = 1'b0;
    logic        eng_dout = 1'b0;

    t_pins       expected_pins[$];
    t_plan_row   directed_plan[$];
    int          mismatches = 0;
    int          items_sent = 0;
    bit          burst_mode = 1'b0;
    int unsigned cycles_run = 0;
    int          rx_run = 0;
    int          rx_stall = 0;

    function automatic void pulse_rise();
        if (!eng_reading) begin
            eng_dout = (eng_send & eng_mask) != 64'd0;
        end
        eng_clk   = 1'b1;
        eng_phase = ENG_HIGH;
        eng_delay = cfg_high;
    endfunction

    // advances the predictor by one item and returns the pin levels after it
    function automatic t_pins predict_tick(logic [OP_W-1:0] op, logic [63:0] word,
                                           logic [6:0] cnt, logic din);
        t_pins r;
        r = '0;
        if (op == OP_OUT || op == OP_IN) begin
            if (eng_phase != ENG_IDLE || cnt == 7'd0 || cnt > 7'(MAX_BITS)) begin
                r.bad = 1'b1;
            end else begin
                eng_reading = (op == OP_IN);
                eng_left    = cnt;
                eng_mask    = cfg_lead_msb ? (64'd1 << (cnt - 7'd1)) : 64'd1;
                if (eng_reading) begin
                    eng_gather = '0;
                    if (cfg_pre && din) eng_gather |= eng_mask;
                end else begin
                    eng_send = word;
                end
                pulse_rise();
            end
        end else if (eng_phase == ENG_HIGH) begin
            if (eng_delay != 8'd0) begin
                eng_delay--;
            end else begin
                eng_clk   = 1'b0;
                eng_phase = ENG_LOW;
                eng_delay = cfg_low;
            end
        end else if (eng_phase == ENG_LOW) begin
            if (eng_delay != 8'd0) begin
                eng_delay--;
            end else begin
                if (eng_reading && !cfg_pre && din) eng_gather |= eng_mask;
                if (eng_left > 7'd1) begin
                    eng_left--;
                    eng_mask = cfg_lead_msb ? (eng_mask >> 1) : (eng_mask << 1);
                    if (eng_reading && cfg_pre && din) eng_gather |= eng_mask;
                    pulse_rise();
                end else begin
                    eng_left    = '0;
                    eng_mask    = '0;
                    eng_reading = 1'b0;
                    eng_clk     = 1'b0;
                    eng_phase   = ENG_IDLE;
                    eng_delay   = '0;
                    r.done      = 1'b1;
                end
            end
        end
        r.clk  = eng_clk;
        r.dout = eng_dout;
        r.busy = (eng_phase != ENG_IDLE);
        r.rd   = eng_gather;
        return r;
    endfunction

    function automatic t_pins mk_pins(logic clk, logic dout, logic busy, logic done,
                                      logic [63:0] rd, logic bad);
        t_pins p;
        p.clk  = clk;
        p.dout = dout;
        p.busy = busy;
        p.done = done;
        p.rd   = rd;
        p.bad  = bad;
        return p;
    endfunction

    function automatic t_plan_row item_row(logic [OP_W-1:0] op, logic [63:0] word,
                                           logic [6:0] cnt, logic din,
                                           logic typed, t_pins want);
        t_plan_row r;
        r.kind  = ROW_ITEM;
        r.op    = op;
        r.word  = word;
        r.cnt   = cnt;
        r.din   = din;
        r.typed = typed;
        r.want  = want;
        r.reps  = 0;
        return r;
    endfunction

    function automatic t_plan_row ticks_row(int reps);
        t_plan_row r;
        r.kind  = ROW_TICKS;
        r.typed = 1'b0;
        r.reps  = reps;
        return r;
    endfunction

    function automatic t_plan_row cfg_row(logic [CFG_INDEX_W-1:0] idx,
                                          logic [CFG_DATA_W-1:0] val);
        t_plan_row r;
        r.kind    = ROW_CFG;
        r.typed   = 1'b0;
        r.reg_idx = idx;
        r.reg_val = val;
        r.reps    = 0;
        return r;
    endfunction

    function automatic logic [63:0] rand_word();
        return {$urandom, $urandom};
    endfunction

    // mostly short gaps, now and then a long one
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 80);
    endfunction

    function automatic logic [6:0] pick_count(bit slow);
        int r;
        if (slow) return 7'($urandom_range(1, 2));
        r = $urandom_range(0, 99);
        if (r < 75) return 7'($urandom_range(1, 12));
        if (r < 95) return 7'($urandom_range(13, 63));
        return 7'(MAX_BITS);
    endfunction

    function automatic logic [OP_W-1:0] start_op();
        return ($urandom_range(0, 1) != 0) ? OP_IN : OP_OUT;
    endfunction

    function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
        if (want !== got) begin
            $error("%s: expected %h, got %h", name, want, got);
            mismatches++;
        end
    endfunction

    task automatic send_item(input logic [OP_W-1:0] op, input logic [63:0] word,
                             input logic [6:0] cnt, input logic din);
        int gap;
        gap = burst_mode ? 0 : idle_len();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {din, cnt, word};
        s_axis_tuser  <= op;
        do @(posedge i_clk); while (!s_axis_tready);
        expected_pins.push_back(predict_tick(op, word, cnt, din));
        items_sent++;
    endtask

    task automatic send_tick();
        send_item(($urandom_range(0, 15) == 0) ? OP_SPARE : OP_TICK, rand_word(),
                  7'($urandom), 1'($urandom));
    endtask

    // hold the sender until every pending result has been taken
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (expected_pins.size() != 0) @(posedge i_clk);
        repeat (2) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        drain_results();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_LEAD_MSB:   cfg_lead_msb = val[0];
            CFG_HIGH_TICKS: cfg_high = val;
            CFG_LOW_TICKS:  cfg_low = val;
            CFG_SAMPLE_PRE: cfg_pre = val[0];
            default: ;
        endcase
        i_cfg_valid <= 1'b0;
    endtask

    // one start command, then ticks until the engine goes idle, with some
    // refused starts and register writes mixed in mid-transfer
    task automatic run_transfer(input bit slow);
        int r;
        send_item(start_op(), rand_word(), pick_count(slow), 1'($urandom));
        while (eng_phase != ENG_IDLE) begin
            r = $urandom_range(0, 299);
            if (r == 0) begin
                case ($urandom_range(0, 3))
                    0: write_reg(CFG_LEAD_MSB, 8'($urandom_range(0, 1)));
                    1: write_reg(CFG_HIGH_TICKS, 8'($urandom_range(0, 3)));
                    2: write_reg(CFG_LOW_TICKS, 8'($urandom_range(0, 3)));
                    default: write_reg(CFG_SAMPLE_PRE, 8'($urandom_range(0, 1)));
                endcase
            end else if (r < 8) begin
                send_item(start_op(), rand_word(), 7'($urandom), 1'($urandom));
            end else begin
                send_tick();
            end
        end
    endtask

    // receiver: runs of ready broken by stalls of random length
    always @(posedge i_clk) begin
        if (rx_run == 0 && rx_stall == 0) begin
            rx_run   = $urandom_range(1, 60);
            rx_stall = idle_len();
        end
        if (rx_stall > 0) begin
            rx_stall--;
            m_axis_tready <= 1'b0;
        end else begin
            rx_run--;
            m_axis_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin : result_check
        t_pins want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_pins.size() == 0) begin
                $error("result transfer with no expected result: %h", m_axis_tdata);
                mismatches++;
            end else begin
                want = expected_pins.pop_front();
                check_field("clock_level", 64'(want.clk), 64'(m_axis_tdata[0]));
                check_field("data_out_level", 64'(want.dout), 64'(m_axis_tdata[1]));
                check_field("busy_res", 64'(want.busy), 64'(m_axis_tdata[2]));
                check_field("done_res", 64'(want.done), 64'(m_axis_tdata[3]));
                check_field("read_word", want.rd, m_axis_tdata[67:4]);
                check_field("bad_request", 64'(want.bad), 64'(m_axis_tdata[68]));
                check_field("pad", 64'd0, 64'(m_axis_tdata[71:69]));
            end
        end
    end

    always @(posedge i_clk) begin
        cycles_run++;
        if (cycles_run > CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial begin : stimulus
        t_plan_row   row;
        int          n;
        int          r;
        int          phase_end;
        int          random_start;
        int          span;
        bit          slow;
        logic        msb;
        logic        pre;
        logic [7:0]  hi;
        logic [7:0]  lo;
        logic [63:0] ones;

        ones = '1;
        // configuration at reset: lsb first, no extra ticks, sample after the pulse
        directed_plan.push_back(item_row(OP_TICK, '0, '0, 1'b0, 1'b1,
                                         mk_pins(1'b0, 1'b0, 1'b0, 1'b0, '0, 1'b0)));
        directed_plan.push_back(item_row(OP_SPARE, ones, 7'd127, 1'b1, 1'b1,
                                         mk_pins(1'b0, 1'b0, 1'b0, 1'b0, '0, 1'b0)));
        directed_plan.push_back(item_row(OP_OUT, ones, 7'd0, 1'b1, 1'b1,
                                         mk_pins(1'b0, 1'b0, 1'b0, 1'b0, '0, 1'b1)));
        directed_plan.push_back(item_row(OP_IN, ones, 7'd65, 1'b1, 1'b1,
                                         mk_pins(1'b0, 1'b0, 1'b0, 1'b0, '0, 1'b1)));
        directed_plan.push_back(item_row(OP_IN, '0, 7'd127, 1'b0, 1'b1,
                                         mk_pins(1'b0, 1'b0, 1'b0, 1'b0, '0, 1'b1)));
        directed_plan.push_back(item_row(OP_OUT, 64'd1, 7'd1, 1'b0, 1'b1,
                                         mk_pins(1'b1, 1'b1, 1'b1, 1'b0, '0, 1'b0)));
        // start while busy is refused
        directed_plan.push_back(item_row(OP_OUT, ones, 7'd5, 1'b0, 1'b0, '0));
        directed_plan.push_back(ticks_row(0));
        directed_plan.push_back(item_row(OP_IN, '0, 7'd64, 1'b1, 1'b0, '0));
        directed_plan.push_back(ticks_row(0));
        directed_plan.push_back(cfg_row(CFG_LEAD_MSB, 8'd1));
        directed_plan.push_back(cfg_row(CFG_SAMPLE_PRE, 8'd1));
        // full-width words, first mask at bit 63
        directed_plan.push_back(item_row(OP_OUT, 64'hA5C3_0F96_5A3C_F069, 7'd64, 1'b0,
                                         1'b0, '0));
        directed_plan.push_back(ticks_row(0));
        directed_plan.push_back(item_row(OP_IN, ones, 7'd64, 1'b1, 1'b0, '0));
        directed_plan.push_back(ticks_row(0));
        // bit order flipped mid shift-out: mask runs off the low end
        directed_plan.push_back(cfg_row(CFG_LEAD_MSB, 8'd0));
        directed_plan.push_back(item_row(OP_OUT, ones, 7'd8, 1'b1, 1'b0, '0));
        directed_plan.push_back(ticks_row(4));
        directed_plan.push_back(cfg_row(CFG_LEAD_MSB, 8'd1));
        directed_plan.push_back(cfg_row(CFG_HIGH_TICKS, 8'd2));
        directed_plan.push_back(ticks_row(0));
        // same for shift-in with a delay change on the way
        directed_plan.push_back(cfg_row(CFG_LEAD_MSB, 8'd0));
        directed_plan.push_back(cfg_row(CFG_HIGH_TICKS, 8'd0));
        directed_plan.push_back(item_row(OP_IN, '0, 7'd8, 1'b1, 1'b0, '0));
        directed_plan.push_back(ticks_row(4));
        directed_plan.push_back(cfg_row(CFG_LEAD_MSB, 8'd1));
        directed_plan.push_back(cfg_row(CFG_LOW_TICKS, 8'd1));
        directed_plan.push_back(ticks_row(0));
        // msb-first 64 bits flipped to lsb-first: mask runs off the high end
        directed_plan.push_back(cfg_row(CFG_SAMPLE_PRE, 8'd0));
        directed_plan.push_back(cfg_row(CFG_LOW_TICKS, 8'd0));
        directed_plan.push_back(item_row(OP_IN, '0, 7'd64, 1'b1, 1'b0, '0));
        directed_plan.push_back(ticks_row(4));
        directed_plan.push_back(cfg_row(CFG_LEAD_MSB, 8'd0));
        directed_plan.push_back(ticks_row(0));

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_plan[i]) begin
            row = directed_plan[i];
            burst_mode = ($urandom_range(0, 2) == 0);
            case (row.kind)
                ROW_CFG: write_reg(row.reg_idx, row.reg_val);
                ROW_TICKS: begin
                    n = 0;
                    while ((row.reps == 0) ? (eng_phase != ENG_IDLE) : (n < row.reps)) begin
                        send_tick();
                        n++;
                    end
                end
                default: begin
                    send_item(row.op, row.word, row.cnt, row.din);
                    if (row.typed) expected_pins[expected_pins.size() - 1] = row.want;
                end
            endcase
        end

        // the random part fills up to the overall item budget
        random_start = items_sent;
        span = (TOTAL_ITEMS - random_start) / N_PHASES;
        for (int p = 0; p < N_PHASES; p++) begin
            case (p)
                0: begin msb = 0; hi = 8'd0;   lo = 8'd0;   pre = 0; end
                1: begin msb = 1; hi = 8'd0;   lo = 8'd0;   pre = 1; end
                2: begin msb = 1; hi = 8'd1;   lo = 8'd0;   pre = 1; end
                3: begin msb = 0; hi = 8'd2;   lo = 8'd1;   pre = 0; end
                4: begin msb = 0; hi = 8'd0;   lo = 8'd255; pre = 1; end
                5: begin msb = 1; hi = 8'd255; lo = 8'd0;   pre = 0; end
                default: begin
                    msb = 1'($urandom);
                    pre = 1'($urandom);
                    hi  = 8'($urandom_range(0, ($urandom_range(0, 3) == 0) ? 20 : 3));
                    lo  = 8'($urandom_range(0, ($urandom_range(0, 3) == 0) ? 20 : 3));
                end
            endcase
            write_reg(CFG_LEAD_MSB, 8'(msb));
            write_reg(CFG_HIGH_TICKS, hi);
            write_reg(CFG_LOW_TICKS, lo);
            write_reg(CFG_SAMPLE_PRE, 8'(pre));
            slow = (int'(hi) + int'(lo)) > 24;
            phase_end = random_start + (p + 1) * span;
            do begin
                burst_mode = ($urandom_range(0, 4) == 0);
                r = $urandom_range(0, 99);
                if (r < 82) begin
                    run_transfer(slow);
                end else if (r < 90) begin
                    send_tick();
                end else if (r < 95) begin
                    send_item(start_op(), rand_word(), 7'd0, 1'($urandom));
                end else begin
                    send_item(start_op(), rand_word(), 7'($urandom_range(65, 127)),
                              1'($urandom));
                end
            end while (items_sent < phase_end);
        end

        drain_results();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
src/sse_pkg.sv
src/serial_shift_engine.sv
tb/sv/testbench.sv
